// ----- hw/rtl/sstu_pkg.sv -----
// Shared types, constants and the segment table of the sample-to-seven-segment unit.
// Depends on nothing; every other file imports it.
package sstu_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 7;
   localparam int POS_W     = 2;
   localparam int POSITIONS = 4;

   localparam logic [SAMPLE_W-1:0] THOUSAND = 10'd1000;
   localparam int                  HUNDRED  = 100;
   localparam int                  TEN      = 10;

   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
   localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

   localparam logic [POSITIONS-1:0] ANODES_OFF = 4'hF;

   // Decimal digits of one sample, thousands is 0 or 1.
   typedef struct packed {
      logic               thou;
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
   } digits_type;

   // Encoded display word: active-low patterns per position and blank flags.
   typedef struct packed {
      logic [POSITIONS-1:0][SEG_W-1:0] seg_n;
      logic [POSITIONS-1:0]            blank;
   } seg_word_type;

   // Lit-segment pattern (1 = lit), bit0 = A .. bit6 = G.
   function automatic logic [SEG_W-1:0] lit_pattern(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 7'h3F;
         4'd1:    p = 7'h06;
         4'd2:    p = 7'h5B;
         4'd3:    p = 7'h4F;
         4'd4:    p = 7'h66;
         4'd5:    p = 7'h6D;
         4'd6:    p = 7'h7D;
         4'd7:    p = 7'h07;
         4'd8:    p = 7'h7F;
         4'd9:    p = 7'h6F;
         default: p = 7'h00;
      endcase
      return p;
   endfunction

endpackage

// ----- hw/rtl/sstu_if.sv -----
// Valid/ready channel interfaces for the sample input and the digit result.
// Depends on sstu_pkg for field widths.
interface sstu_req_if import sstu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source(output valid, output sample, input ready);
   modport sink(input valid, input sample, output ready);
endinterface

interface sstu_rsp_if import sstu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [POS_W-1:0]     position;
   logic [SEG_W-1:0]     segments_n;
   logic [POSITIONS-1:0] anodes_n;
   logic                 last;

   modport source(output valid, output position, output segments_n, output anodes_n,
                  output last, input ready);
   modport sink(input valid, input position, input segments_n, input anodes_n,
                input last, output ready);
endinterface

// ----- hw/rtl/sample_to_multiplexed_seven_segment_unit.sv -----
// Sample to multiplexed seven-segment unit: one 10-bit sample in, four position items out.
// Path: three split registers, the encode register, then the output register to rsp_ch.
// The output register takes a new sample once its four-item walk has its units item taken;
// while that walk runs the split and encode stages keep taking samples until all four fill.
// Reset (synchronous, active high) clears all valid bits; no data is kept across it.
// Depends on sstu_pkg, sstu_if and the sstu_* stage modules.
module sample_to_multiplexed_seven_segment_unit import sstu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sstu_req_if.sink   req_ch,
   sstu_rsp_if.source rsp_ch
);

   // Split stages to encode stage.
   logic         dig_valid, dig_ready;
   digits_type   dig_data;

   // Encode stage to output walk.
   logic         word_valid, word_ready;
   seg_word_type word_data;

   // Thousands, hundreds, then tens and units, one register stage each.
   sstu_digit_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_sample  (req_ch.sample),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (dig_data)
   );

   // Look up segment patterns and resolve leading-zero blanking.
   sstu_seg_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_digits (dig_data),
      .out_valid (word_valid),
      .out_ready (word_ready),
      .out_word  (word_data)
   );

   // Hold one word and emit its positions left to right; take the next word
   // on the same edge the units item leaves.
   sstu_serializer u_walk (
      .clock    (clock),
      .reset    (reset),
      .in_valid (word_valid),
      .in_ready (word_ready),
      .in_word  (word_data),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- hw/rtl/sstu_digit_split.sv -----
// Three-stage decimal split of a 10-bit sample: thousands, hundreds, tens/units.
// Depends on sstu_pkg.
module sstu_digit_split import sstu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   output logic                out_valid,
   input  logic                out_ready,
   output digits_type          out_digits
);

   logic                s1_valid_ff, s1_thou_ff;
   logic [SAMPLE_W-1:0] s1_rem_ff;
   logic                s1_thou_in;
   logic [SAMPLE_W-1:0] s1_rem_in;

   logic               s2_valid_ff, s2_thou_ff;
   logic [DIGIT_W-1:0] s2_hund_ff;
   logic [6:0]         s2_rem_ff;
   logic [DIGIT_W-1:0] s2_hund_in;
   logic [6:0]         s2_rem_in;

   logic               s3_valid_ff;
   digits_type         s3_digits_ff;
   logic [DIGIT_W-1:0] s3_tens_in, s3_units_in;

   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Strip the thousands.
   always_comb begin
      s1_thou_in = (in_sample >= THOUSAND);
      s1_rem_in  = s1_thou_in ? in_sample - THOUSAND : in_sample;
   end

   // Hundreds by parallel compares against constant steps.
   always_comb begin
      s2_hund_in = '0;
      s2_rem_in  = s1_rem_ff[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (s1_rem_ff >= SAMPLE_W'(k * HUNDRED)) begin
            s2_hund_in = DIGIT_W'(k);
            s2_rem_in  = 7'(s1_rem_ff - SAMPLE_W'(k * HUNDRED));
         end
      end
   end

   // Tens and units the same way.
   always_comb begin
      s3_tens_in  = '0;
      s3_units_in = s2_rem_ff[DIGIT_W-1:0];
      for (int k = 1; k <= 9; k++) begin
         if (s2_rem_ff >= 7'(k * TEN)) begin
            s3_tens_in  = DIGIT_W'(k);
            s3_units_in = DIGIT_W'(s2_rem_ff - 7'(k * TEN));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_thou_ff <= s1_thou_in;
         s1_rem_ff  <= s1_rem_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_thou_ff <= s1_thou_ff;
         s2_hund_ff <= s2_hund_in;
         s2_rem_ff  <= s2_rem_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_digits_ff.thou  <= s2_thou_ff;
         s3_digits_ff.hund  <= s2_hund_ff;
         s3_digits_ff.tens  <= s3_tens_in;
         s3_digits_ff.units <= s3_units_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_digits = s3_digits_ff;

endmodule

// ----- hw/rtl/sstu_seg_encode.sv -----
// Segment encode and leading-zero blanking stage.
// Depends on sstu_pkg for the digit table and word types.
module sstu_seg_encode import sstu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  digits_type   in_digits,
   output logic         out_valid,
   input  logic         out_ready,
   output seg_word_type out_word
);

   logic         valid_ff;
   seg_word_type word_ff, word_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in.seg_n[0] = ~lit_pattern({3'b000, in_digits.thou});
      word_in.seg_n[1] = ~lit_pattern(in_digits.hund);
      word_in.seg_n[2] = ~lit_pattern(in_digits.tens);
      word_in.seg_n[3] = ~lit_pattern(in_digits.units);
      // Blank leading zeros; never the units.
      word_in.blank[0] = !in_digits.thou;
      word_in.blank[1] = word_in.blank[0] && (in_digits.hund == '0);
      word_in.blank[2] = word_in.blank[1] && (in_digits.tens == '0);
      word_in.blank[3] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- hw/rtl/sstu_serializer.sv -----
// Output register that walks one display word out as four position items.
// Depends on sstu_pkg and the result channel interface.
module sstu_serializer import sstu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  seg_word_type  in_word,
   sstu_rsp_if.source    rsp_ch
);

   logic             valid_ff;
   logic [POS_W-1:0] pos_ff;
   seg_word_type     word_ff;
   logic             done;

   assign done     = rsp_ch.valid && rsp_ch.ready && (pos_ff == POS_UNITS);
   assign in_ready = !valid_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= POS_THOUSANDS;
      end else if (in_ready) begin
         valid_ff <= in_valid;
         pos_ff   <= POS_THOUSANDS;
      end else if (rsp_ch.ready) begin
         pos_ff <= pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) word_ff <= in_word;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.position   = pos_ff;
   assign rsp_ch.segments_n = word_ff.seg_n[pos_ff];
   assign rsp_ch.anodes_n   = word_ff.blank[pos_ff] ? ANODES_OFF
                                                    : ~(POSITIONS'(1) << pos_ff);
   assign rsp_ch.last       = (pos_ff == POS_UNITS);

   a_last_on_units: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last == (rsp_ch.position == POS_UNITS)))
      else $error("last flag out of step with position");

   a_units_shown: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.position == POS_UNITS) |-> (rsp_ch.anodes_n == 4'b0111))
      else $error("units position not enabled");

   a_one_anode: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ($countones(rsp_ch.anodes_n) >= 3))
      else $error("more than one anode enabled");

   a_position_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=>
         (rsp_ch.valid && rsp_ch.position == $past(rsp_ch.position) + 2'd1))
      else $error("position did not advance after a taken item");

endmodule
